FILE: rtl/cmf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmf_pkg
// Constants shared by the chunked message framer: field widths, header
// codes, tag bytes and size limits of the framing.
// ----------------------------------------------------------------------------
package cmf_pkg;

    // field widths
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 16;

    // header and tag bytes
    localparam logic [BYTE_W-1:0] HDR_LONG   = 8'hff;
    localparam logic [BYTE_W-1:0] HDR_TYPE   = 8'h01;
    localparam logic [BYTE_W-1:0] CHUNK_MARK = 8'hff;
    localparam logic [BYTE_W-1:0] TAG_FIRST  = 8'h4d;  // 'M'
    localparam logic [BYTE_W-1:0] TAG_SECOND = 8'h32;  // '2'

    // size limits
    localparam logic [LEN_W-1:0]  SHORT_LIMIT = 16'h00fe;
    localparam logic [BYTE_W-1:0] FIRST_SPAN  = 8'hfd;
    localparam logic [LEN_W-1:0]  CHUNK_MAX   = 16'h00ff;
    localparam logic [LEN_W-1:0]  TAG_LEN     = 16'd2;

endpackage

FILE: rtl/chunked_message_framer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chunked_message_framer
// Frames payload bytes into length-prefixed messages with a two-byte tag,
// splitting long messages into chunks that each carry a chunk header.
// ----------------------------------------------------------------------------
// One accepted payload byte is held in an input register and stepped through
// a small phase sequencer that writes one framed byte per cycle into the
// output register while it is free. A payload byte in the middle of a message
// emits only the data byte, so the sustained rate is one byte per cycle while
// m_tready stays high. The first byte of a message emits four header bytes,
// two tag bytes and the data byte, the data byte dropped when the payload
// length is zero; a byte that opens a new chunk of a long message emits the
// chunk length, the chunk mark and the data byte. An oversized message emits
// only its error transfer; other bytes that produce no output are dropped.
// The input is taken in the same cycle the held byte finishes, and the output
// register takes a new byte in the same cycle m_tready accepts its last one.
module chunked_message_framer (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] payload_byte, [23:8] payload_length
    input  logic [0:0]  s_tuser,   // [0] first_of_message
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tlast,   // last_of_message
    output logic [0:0]  m_tuser    // [0] oversize_error
);

    typedef enum logic [3:0] {
        PH_ENTRY,
        PH_HDR1,
        PH_HDR2,
        PH_HDR3,
        PH_TAG_M,
        PH_TAG_2,
        PH_CHK_LEN,
        PH_CHK_FF,
        PH_DATA
    } phase_t;

    // held input item
    logic                       item_valid_reg, item_valid_next;
    logic [cmf_pkg::BYTE_W-1:0] item_byte_reg, item_byte_next;
    logic [cmf_pkg::LEN_W-1:0]  item_len_reg, item_len_next;
    logic                       item_first_reg, item_first_next;
    phase_t                     phase_reg, phase_next;

    // message state
    logic [cmf_pkg::LEN_W-1:0]  position_reg, position_next;
    logic [cmf_pkg::LEN_W-1:0]  total_reg, total_next;
    logic [cmf_pkg::BYTE_W-1:0] chunk_reg, chunk_next;
    logic                       long_form_reg, long_form_next;
    logic                       dropping_reg, dropping_next;

    // output register
    logic                       m_valid_reg, m_valid_next;
    logic [cmf_pkg::BYTE_W-1:0] m_byte_reg, m_byte_next;
    logic                       m_last_reg, m_last_next;
    logic                       m_err_reg, m_err_next;

    // helpers
    logic                       out_free;
    logic                       emit;
    logic                       done;
    logic                       s_accept;
    logic [cmf_pkg::LEN_W:0]    new_total;
    logic                       oversize;
    logic [cmf_pkg::LEN_W-1:0]  remain;
    logic [cmf_pkg::BYTE_W-1:0] remain_sat;
    logic                       last_flag;
    logic [cmf_pkg::BYTE_W-1:0] chunk_dec;
    logic [cmf_pkg::BYTE_W-1:0] emit_byte;
    logic                       emit_last;
    logic                       emit_err;

    assign out_free  = !m_valid_reg || m_tready;
    assign new_total = {1'b0, item_len_reg} + {1'b0, cmf_pkg::TAG_LEN};
    assign oversize  = new_total[cmf_pkg::LEN_W];
    assign remain    = total_reg - position_reg;
    assign remain_sat = (remain > cmf_pkg::CHUNK_MAX) ? cmf_pkg::CHUNK_MAX[cmf_pkg::BYTE_W-1:0]
                                                      : remain[cmf_pkg::BYTE_W-1:0];
    assign last_flag = ({1'b0, position_reg} + 17'd1) == {1'b0, total_reg};
    assign chunk_dec = (long_form_reg && chunk_reg != '0) ? chunk_reg - 8'd1 : chunk_reg;

    // phase sequencer: one framed byte per cycle for the held item while the output register is free
    always_comb begin
        position_next  = position_reg;
        total_next     = total_reg;
        chunk_next     = chunk_reg;
        long_form_next = long_form_reg;
        dropping_next  = dropping_reg;
        phase_next     = phase_reg;
        emit           = 1'b0;
        done           = 1'b0;
        emit_byte      = '0;
        emit_last      = 1'b0;
        emit_err       = 1'b0;
        if (item_valid_reg) begin
            case (phase_reg)
                PH_ENTRY: begin
                    if (item_first_reg) begin
                        if (out_free) begin
                            emit = 1'b1;
                            if (oversize) begin
                                emit_err       = 1'b1;
                                dropping_next  = 1'b1;
                                position_next  = '0;
                                total_next     = '0;
                                chunk_next     = '0;
                                long_form_next = 1'b0;
                                done           = 1'b1;
                            end else begin
                                dropping_next = 1'b0;
                                total_next    = new_total[cmf_pkg::LEN_W-1:0];
                                position_next = '0;
                                if (new_total[cmf_pkg::LEN_W-1:0] < cmf_pkg::SHORT_LIMIT) begin
                                    long_form_next = 1'b0;
                                    chunk_next     = '0;
                                    emit_byte      = new_total[cmf_pkg::BYTE_W-1:0] + 8'd2;
                                end else begin
                                    long_form_next = 1'b1;
                                    chunk_next     = cmf_pkg::FIRST_SPAN;
                                    emit_byte      = cmf_pkg::HDR_LONG;
                                end
                                phase_next = PH_HDR1;
                            end
                        end
                    end else if (dropping_reg || position_reg >= total_reg) begin
                        // no open message: drop silently
                        done = 1'b1;
                    end else if (long_form_reg && chunk_reg == '0) begin
                        if (out_free) begin
                            emit       = 1'b1;
                            emit_byte  = remain_sat;
                            chunk_next = remain_sat;
                            phase_next = PH_CHK_FF;
                        end
                    end else if (out_free) begin
                        emit          = 1'b1;
                        emit_byte     = item_byte_reg;
                        emit_last     = last_flag;
                        position_next = position_reg + 16'd1;
                        chunk_next    = chunk_dec;
                        done          = 1'b1;
                    end
                end
                PH_HDR1: begin
                    if (out_free) begin
                        emit       = 1'b1;
                        emit_byte  = cmf_pkg::HDR_TYPE;
                        phase_next = PH_HDR2;
                    end
                end
                PH_HDR2: begin
                    if (out_free) begin
                        emit       = 1'b1;
                        emit_byte  = total_reg[15:8];
                        phase_next = PH_HDR3;
                    end
                end
                PH_HDR3: begin
                    if (out_free) begin
                        emit       = 1'b1;
                        emit_byte  = total_reg[7:0];
                        phase_next = PH_TAG_M;
                    end
                end
                PH_TAG_M, PH_TAG_2: begin
                    if (out_free) begin
                        emit          = 1'b1;
                        emit_byte     = (phase_reg == PH_TAG_M) ? cmf_pkg::TAG_FIRST
                                                                : cmf_pkg::TAG_SECOND;
                        emit_last     = last_flag;
                        position_next = position_reg + 16'd1;
                        chunk_next    = chunk_dec;
                        if (last_flag) begin
                            done = 1'b1;
                        end else if (phase_reg == PH_TAG_M) begin
                            phase_next = PH_TAG_2;
                        end else if (long_form_reg && chunk_dec == '0) begin
                            phase_next = PH_CHK_LEN;
                        end else begin
                            phase_next = PH_DATA;
                        end
                    end
                end
                PH_CHK_LEN: begin
                    if (out_free) begin
                        emit       = 1'b1;
                        emit_byte  = remain_sat;
                        chunk_next = remain_sat;
                        phase_next = PH_CHK_FF;
                    end
                end
                PH_CHK_FF: begin
                    if (out_free) begin
                        emit       = 1'b1;
                        emit_byte  = cmf_pkg::CHUNK_MARK;
                        phase_next = PH_DATA;
                    end
                end
                PH_DATA: begin
                    if (out_free) begin
                        emit          = 1'b1;
                        emit_byte     = item_byte_reg;
                        emit_last     = last_flag;
                        position_next = position_reg + 16'd1;
                        chunk_next    = chunk_dec;
                        done          = 1'b1;
                    end
                end
                default: begin
                    done = 1'b1;
                end
            endcase
        end
        if (done) begin
            phase_next = PH_ENTRY;
        end
    end

    // input register
    assign s_tready = !item_valid_reg || done;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        item_valid_next = item_valid_reg && !done;
        item_byte_next  = item_byte_reg;
        item_len_next   = item_len_reg;
        item_first_next = item_first_reg;
        if (s_accept) begin
            item_valid_next = 1'b1;
            item_byte_next  = s_tdata[7:0];
            item_len_next   = s_tdata[23:8];
            item_first_next = s_tuser[0];
        end
    end

    // output register
    always_comb begin
        m_valid_next = m_valid_reg && !m_tready;
        m_byte_next  = m_byte_reg;
        m_last_next  = m_last_reg;
        m_err_next   = m_err_reg;
        if (emit) begin
            m_valid_next = 1'b1;
            m_byte_next  = emit_byte;
            m_last_next  = emit_last;
            m_err_next   = emit_err;
        end
    end

    // control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
            phase_reg      <= PH_ENTRY;
            position_reg   <= '0;
            total_reg      <= '0;
            chunk_reg      <= '0;
            long_form_reg  <= 1'b0;
            dropping_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            item_valid_reg <= item_valid_next;
            phase_reg      <= phase_next;
            position_reg   <= position_next;
            total_reg      <= total_next;
            chunk_reg      <= chunk_next;
            long_form_reg  <= long_form_next;
            dropping_reg   <= dropping_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        item_byte_reg  <= item_byte_next;
        item_len_reg   <= item_len_next;
        item_first_reg <= item_first_next;
        m_byte_reg     <= m_byte_next;
        m_last_reg     <= m_last_next;
        m_err_reg      <= m_err_next;
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_byte_reg;
    assign m_tlast    = m_last_reg;
    assign m_tuser[0] = m_err_reg;

    // error transfer carries a zero byte and no last mark
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == '0 && !m_tlast))
        else $error("error transfer carries data or last mark");

    // only long-form messages count chunk bytes
    assert property (@(posedge aclk) disable iff (!aresetn)
        (chunk_reg != '0) |-> long_form_reg)
        else $error("chunk count set outside long form");

    // position never passes the message length
    assert property (@(posedge aclk) disable iff (!aresetn)
        position_reg <= total_reg)
        else $error("message position beyond message length");

    // sequencer only leaves entry phase while an item is held
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg != PH_ENTRY) |-> item_valid_reg)
        else $error("sequencer active without held item");

endmodule
